// ===== hw/rtl/index_block_entry_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the index block entry parser.
// Each macro expects signals named clk and rst_n in the including scope.
// ----------------------------------------------------------------------------
`ifndef INDEX_BLOCK_ENTRY_PARSER_ASSERT_SVH
`define INDEX_BLOCK_ENTRY_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IBEP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IBEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ibep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibep_pkg
// Shared widths, register codes and reset values of the index block entry
// parser.
// ----------------------------------------------------------------------------
package ibep_pkg;

  localparam int unsigned KEY_BYTES_MAX = 16;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned KEY_CFG_W  = 5;
  localparam int unsigned FLD_CFG_W  = 4;
  localparam int unsigned KIB_CFG_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned BLK_CNT_W  = 18;
  localparam int unsigned ENT_CNT_W  = 6;
  localparam int unsigned KIB_SHIFT  = 10;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_KEY_BYTES    = 2'd0,
    CFG_SIZE_BYTES   = 2'd1,
    CFG_OFFSET_BYTES = 2'd2,
    CFG_BLOCK_KIB    = 2'd3
  } cfg_reg_t;

  localparam logic [KEY_CFG_W-1:0] KEY_BYTES_RST    = 5'd9;
  localparam logic [FLD_CFG_W-1:0] SIZE_BYTES_RST   = 4'd4;
  localparam logic [FLD_CFG_W-1:0] OFFSET_BYTES_RST = 4'd4;
  localparam logic [KIB_CFG_W-1:0] BLOCK_KIB_RST    = 8'd4;

  localparam logic [FLD_CFG_W-1:0] FLD_BYTES_MAX = 4'd8;

endpackage

// ===== hw/rtl/ibep_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibep_if
// Valid/ready channels of the index block entry parser: the byte stream in
// and the parsed entry out.
// ----------------------------------------------------------------------------
interface ibep_byte_if;
  import ibep_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ibep_entry_if;
  import ibep_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] key_first;
  logic [WORD_W-1:0] key_second;
  logic [WORD_W-1:0] entry_length;
  logic [WORD_W-1:0] entry_position;

  modport source (output valid, output key_first, output key_second,
                  output entry_length, output entry_position, input ready);
  modport sink   (input valid, input key_first, input key_second,
                  input entry_length, input entry_position, output ready);
endinterface

// ===== hw/rtl/index_block_entry_parser.sv =====
`timescale 1ns / 1ps
// Latency: a request accepted at one edge shows its entry on out_ch after that same edge.
// Throughput: one byte per cycle while the used-length unit is idle and the output is free.
// After reset and after every configuration write the used-length unit runs a load step,
// then one remainder bit per cycle over 18 bits, with in_ch.ready low.
// Reset is synchronous, active low, and restores all but the output data registers.
// ----------------------------------------------------------------------------
// index_block_entry_parser
// Splits the block region of an index file into entries of key, big-endian
// size and big-endian offset, and emits every entry whose key is not zero.
// ----------------------------------------------------------------------------
module index_block_entry_parser #(
  parameter int unsigned MAX_KEY_BYTES = ibep_pkg::KEY_BYTES_MAX
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  ibep_pkg::cfg_reg_t             cfg_idx,
  input  logic [ibep_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ibep_byte_if.sink                      in_ch,
  ibep_entry_if.source                   out_ch
);
  import ibep_pkg::*;

  localparam int unsigned KeyW = MAX_KEY_BYTES * BYTE_W;
  localparam logic [KEY_CFG_W-1:0] KeyMax = KEY_CFG_W'(MAX_KEY_BYTES);

  // --------------------------------------------------------------------------
  // Configuration registers. A write takes effect at once and also restarts
  // the used-length computation below.
  // --------------------------------------------------------------------------
  logic [KEY_CFG_W-1:0] key_cfg_r;
  logic [FLD_CFG_W-1:0] size_cfg_r;
  logic [FLD_CFG_W-1:0] offs_cfg_r;
  logic [KIB_CFG_W-1:0] kib_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_cfg_r  <= KEY_BYTES_RST;
      size_cfg_r <= SIZE_BYTES_RST;
      offs_cfg_r <= OFFSET_BYTES_RST;
      kib_cfg_r  <= BLOCK_KIB_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_KEY_BYTES:    key_cfg_r  <= cfg_wdata[KEY_CFG_W-1:0];
        CFG_SIZE_BYTES:   size_cfg_r <= cfg_wdata[FLD_CFG_W-1:0];
        CFG_OFFSET_BYTES: offs_cfg_r <= cfg_wdata[FLD_CFG_W-1:0];
        CFG_BLOCK_KIB:    kib_cfg_r  <= cfg_wdata[KIB_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register values are clamped into their legal ranges before use: a key
  // length of zero acts as one byte, field lengths saturate at eight bytes,
  // and a block length of zero acts as one KiB.
  logic [KEY_CFG_W-1:0] key_len;
  logic [FLD_CFG_W-1:0] size_len;
  logic [FLD_CFG_W-1:0] offs_len;
  logic [KIB_CFG_W-1:0] kib_len;
  logic [ENT_CNT_W-1:0] key_end;
  logic [ENT_CNT_W-1:0] size_end;
  logic [ENT_CNT_W-1:0] ent_len;
  logic [BLK_CNT_W-1:0] blk_len;

  always_comb begin
    if (key_cfg_r == '0) begin
      key_len = KEY_CFG_W'(1);
    end else if (key_cfg_r > KeyMax) begin
      key_len = KeyMax;
    end else begin
      key_len = key_cfg_r;
    end
    size_len = (size_cfg_r > FLD_BYTES_MAX) ? FLD_BYTES_MAX : size_cfg_r;
    offs_len = (offs_cfg_r > FLD_BYTES_MAX) ? FLD_BYTES_MAX : offs_cfg_r;
    kib_len  = (kib_cfg_r == '0) ? KIB_CFG_W'(1) : kib_cfg_r;
    key_end  = ENT_CNT_W'(key_len);
    size_end = key_end + ENT_CNT_W'(size_len);
    ent_len  = size_end + ENT_CNT_W'(offs_len);
    blk_len  = {kib_len, KIB_SHIFT'(0)};
  end

  // --------------------------------------------------------------------------
  // Used-length unit. The bytes of a block that belong to whole entries are
  // blk_len minus (blk_len mod ent_len). The remainder comes from a
  // restoring division that takes one bit of blk_len per cycle, MSB first.
  // Input requests are held off from reset or a configuration write until
  // the new used length is in place.
  // --------------------------------------------------------------------------
  logic                   calc_start_r;
  logic                   calc_busy_r;
  logic [4:0]             calc_bit_r;
  logic [ENT_CNT_W-1:0]   rem_r;
  logic [BLK_CNT_W-1:0]   used_r;
  logic [ENT_CNT_W:0]     rem_trial;
  logic [ENT_CNT_W-1:0]   rem_nxt;

  always_comb begin
    rem_trial = {rem_r, blk_len[calc_bit_r]};
    if (rem_trial >= {1'b0, ent_len}) begin
      rem_nxt = ENT_CNT_W'(rem_trial - {1'b0, ent_len});
    end else begin
      rem_nxt = rem_trial[ENT_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calc_start_r <= 1'b1;
      calc_busy_r  <= 1'b0;
      calc_bit_r   <= '0;
      rem_r        <= '0;
      used_r       <= '0;
    end else if (cfg_we) begin
      calc_start_r <= 1'b1;
    end else if (calc_start_r) begin
      calc_start_r <= 1'b0;
      calc_busy_r  <= 1'b1;
      calc_bit_r   <= 5'(BLK_CNT_W - 1);
      rem_r        <= '0;
    end else if (calc_busy_r) begin
      rem_r <= rem_nxt;
      if (calc_bit_r == '0) begin
        calc_busy_r <= 1'b0;
        used_r      <= blk_len - BLK_CNT_W'(rem_nxt);
      end else begin
        calc_bit_r <= calc_bit_r - 5'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte path. Everything for one byte is decided in the cycle of its
  // request: the entry state and the output register are loaded at the same
  // edge, so a new byte can follow in every cycle. The output register acts
  // as the stage between the two channels; the next byte is taken as long
  // as the held entry is being taken at the same edge or none is held.
  // --------------------------------------------------------------------------
  logic                 out_valid_r;
  logic                 in_accept;

  assign in_ch.ready = !calc_start_r && !calc_busy_r && (!out_valid_r || out_ch.ready);
  assign in_accept   = in_ch.valid && in_ch.ready;

  logic [BLK_CNT_W-1:0] blk_cnt_r,  blk_cnt_nxt;
  logic [ENT_CNT_W-1:0] ent_cnt_r,  ent_cnt_nxt;
  logic [KeyW-1:0]      key_r,      key_nxt;
  logic                 nonzero_r,  nonzero_nxt;
  logic [WORD_W-1:0]    len_acc_r,  len_acc_nxt;
  logic [WORD_W-1:0]    pos_acc_r,  pos_acc_nxt;
  logic                 emit;
  logic [ENT_CNT_W:0]   ent_pos_inc;
  logic [BLK_CNT_W:0]   blk_cnt_inc;
  logic [BYTE_W-1:0]    din;
  logic [2*WORD_W-1:0]  key_full;
  logic [KeyW-1:0]      key_emit;
  logic [WORD_W-1:0]    len_emit;
  logic [WORD_W-1:0]    pos_emit;

  always_comb begin
    din         = in_ch.data_byte;
    blk_cnt_nxt = blk_cnt_r;
    ent_cnt_nxt = ent_cnt_r;
    key_nxt     = key_r;
    nonzero_nxt = nonzero_r;
    len_acc_nxt = len_acc_r;
    pos_acc_nxt = pos_acc_r;
    key_emit    = key_r;
    len_emit    = len_acc_r;
    pos_emit    = pos_acc_r;
    emit        = 1'b0;
    ent_pos_inc = {1'b0, ent_cnt_r} + 7'd1;
    blk_cnt_inc = {1'b0, blk_cnt_r} + 19'd1;

    // Bytes past the last whole entry of a block are padding.
    if (blk_cnt_r < used_r) begin
      if (ent_cnt_r < key_end) begin
        for (int unsigned i = 0; i < MAX_KEY_BYTES; i++) begin
          if (ent_cnt_r[3:0] == 4'(i)) begin
            key_nxt[KeyW-1-BYTE_W*i -: BYTE_W] = key_r[KeyW-1-BYTE_W*i -: BYTE_W] | din;
          end
        end
        if (din != '0) begin
          nonzero_nxt = 1'b1;
        end
      end else if (ent_cnt_r < size_end) begin
        len_acc_nxt = {len_acc_r[WORD_W-BYTE_W-1:0], din};
      end else if (ent_cnt_r < ent_len) begin
        pos_acc_nxt = {pos_acc_r[WORD_W-BYTE_W-1:0], din};
      end

      // The fields including this byte, taken before any clearing below.
      key_emit = key_nxt;
      len_emit = len_acc_nxt;
      pos_emit = pos_acc_nxt;

      if (ent_pos_inc >= {1'b0, ent_len}) begin
        // Last byte of an entry: report it unless the key is all zeros.
        emit        = nonzero_nxt;
        ent_cnt_nxt = '0;
        key_nxt     = '0;
        nonzero_nxt = 1'b0;
        len_acc_nxt = '0;
        pos_acc_nxt = '0;
      end else begin
        ent_cnt_nxt = ent_pos_inc[ENT_CNT_W-1:0];
      end
    end

    // A block end drops whatever partial entry is in flight.
    if (blk_cnt_inc >= {1'b0, blk_len}) begin
      blk_cnt_nxt = '0;
      ent_cnt_nxt = '0;
      key_nxt     = '0;
      nonzero_nxt = 1'b0;
      len_acc_nxt = '0;
      pos_acc_nxt = '0;
    end else begin
      blk_cnt_nxt = blk_cnt_inc[BLK_CNT_W-1:0];
    end
  end

  // The key store is left-aligned into the two output words; bytes beyond
  // the store read as zero.
  always_comb begin
    key_full = '0;
    key_full[2*WORD_W-1 -: KeyW] = key_emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_cnt_r <= '0;
      ent_cnt_r <= '0;
      key_r     <= '0;
      nonzero_r <= 1'b0;
      len_acc_r <= '0;
      pos_acc_r <= '0;
    end else if (in_accept) begin
      blk_cnt_r <= blk_cnt_nxt;
      ent_cnt_r <= ent_cnt_nxt;
      key_r     <= key_nxt;
      nonzero_r <= nonzero_nxt;
      len_acc_r <= len_acc_nxt;
      pos_acc_r <= pos_acc_nxt;
    end
  end

  // Output register.
  logic [WORD_W-1:0] key_first_r;
  logic [WORD_W-1:0] key_second_r;
  logic [WORD_W-1:0] length_r;
  logic [WORD_W-1:0] position_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      key_first_r  <= key_full[2*WORD_W-1:WORD_W];
      key_second_r <= key_full[WORD_W-1:0];
      length_r     <= len_emit;
      position_r   <= pos_emit;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.key_first      = key_first_r;
  assign out_ch.key_second     = key_second_r;
  assign out_ch.entry_length   = length_r;
  assign out_ch.entry_position = position_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
`include "index_block_entry_parser_assert.svh"

  `IBEP_ASSERT_NEXT(a_cfg_holds_input, cfg_we, !in_ch.ready, "byte taken right after a cfg write")
  `IBEP_ASSERT_NOW(a_used_in_block, !calc_start_r && !calc_busy_r, used_r <= blk_len,
                   "used length exceeds block length")
  `IBEP_ASSERT_NOW(a_out_from_accept, $rose(out_valid_r), $past(in_accept),
                   "entry appeared without an accepted byte")
  `IBEP_ASSERT_NOW(a_entry_cnt_range, 1'b1, ent_cnt_r < 6'd32,
                   "entry byte counter beyond longest entry")

endmodule

// ===== tb/ibep_entry_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibep_entry_checker
// Watches the byte and entry channels of the index block entry parser. It
// tracks the register settings and the block and entry position of the
// stream, and works out each entry that the parser must emit. Every entry
// taken from the parser is compared field by field with the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module ibep_entry_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  ibep_pkg::cfg_reg_t              cfg_idx,
  input  logic [ibep_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ibep_byte_if                            byte_ch,
  ibep_entry_if                           entry_ch,
  output int                              fail_count,
  output int                              pending_count
);
  import ibep_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] key_first;
    logic [WORD_W-1:0] key_second;
    logic [WORD_W-1:0] entry_length;
    logic [WORD_W-1:0] entry_position;
  } entry_t;

  logic [KEY_CFG_W-1:0] key_cfg;
  logic [FLD_CFG_W-1:0] size_cfg;
  logic [FLD_CFG_W-1:0] offset_cfg;
  logic [KIB_CFG_W-1:0] kib_cfg;

  logic [BLK_CNT_W-1:0] block_pos;
  logic [ENT_CNT_W-1:0] entry_pos;
  logic [WORD_W-1:0]    key_word [2];
  logic                 key_live;
  logic [WORD_W-1:0]    length_acc;
  logic [WORD_W-1:0]    position_acc;

  entry_t pending_entries [$];

  function automatic void drop_partial_entry();
    entry_pos    = '0;
    key_word[0]  = '0;
    key_word[1]  = '0;
    key_live     = 1'b0;
    length_acc   = '0;
    position_acc = '0;
  endfunction

  // Advances the parse by one byte of the block region.
  task automatic absorb_byte(input logic [BYTE_W-1:0] b);
    int unsigned klen, slen, olen, kib, blen, elen, used, pos, nxt;
    entry_t      e;
    klen = 32'(key_cfg);
    if (klen < 1) klen = 1;
    if (klen > KEY_BYTES_MAX) klen = KEY_BYTES_MAX;
    slen = 32'(size_cfg);
    if (slen > 32'(FLD_BYTES_MAX)) slen = 32'(FLD_BYTES_MAX);
    olen = 32'(offset_cfg);
    if (olen > 32'(FLD_BYTES_MAX)) olen = 32'(FLD_BYTES_MAX);
    kib = 32'(kib_cfg);
    if (kib < 1) kib = 1;

    blen = kib << KIB_SHIFT;
    elen = klen + slen + olen;
    used = (blen / elen) * elen;

    // Bytes past the last whole entry of a block are padding.
    if (32'(block_pos) < used) begin
      pos = 32'(entry_pos);
      if (pos < klen) begin
        key_word[pos[3]] = key_word[pos[3]] | (WORD_W'(b) << ((7 - (pos % 8)) * 8));
        if (b != '0) key_live = 1'b1;
      end else if (pos < klen + slen) begin
        length_acc = (length_acc << BYTE_W) | WORD_W'(b);
      end else if (pos < elen) begin
        position_acc = (position_acc << BYTE_W) | WORD_W'(b);
      end
      pos++;
      if (pos >= elen) begin
        if (key_live) begin
          e.key_first      = key_word[0];
          e.key_second     = key_word[1];
          e.entry_length   = length_acc;
          e.entry_position = position_acc;
          pending_entries.push_back(e);
        end
        drop_partial_entry();
      end else begin
        entry_pos = pos[ENT_CNT_W-1:0];
      end
    end

    nxt = 32'(block_pos) + 1;
    if (nxt >= blen) begin
      nxt = 0;
      drop_partial_entry();
    end
    block_pos = nxt[BLK_CNT_W-1:0];
  endtask

  function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic compare_entry();
    entry_t want;
    if (pending_entries.size() == 0) begin
      $error("unexpected entry: key_first %h key_second %h length %h position %h",
             entry_ch.key_first, entry_ch.key_second, entry_ch.entry_length,
             entry_ch.entry_position);
      fail_count++;
    end else begin
      want = pending_entries.pop_front();
      check_field("key_first", want.key_first, entry_ch.key_first);
      check_field("key_second", want.key_second, entry_ch.key_second);
      check_field("entry_length", want.entry_length, entry_ch.entry_length);
      check_field("entry_position", want.entry_position, entry_ch.entry_position);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_cfg    = KEY_BYTES_RST;
      size_cfg   = SIZE_BYTES_RST;
      offset_cfg = OFFSET_BYTES_RST;
      kib_cfg    = BLOCK_KIB_RST;
      block_pos  = '0;
      drop_partial_entry();
      pending_entries.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_KEY_BYTES:    key_cfg    = cfg_wdata[KEY_CFG_W-1:0];
          CFG_SIZE_BYTES:   size_cfg   = cfg_wdata[FLD_CFG_W-1:0];
          CFG_OFFSET_BYTES: offset_cfg = cfg_wdata[FLD_CFG_W-1:0];
          CFG_BLOCK_KIB:    kib_cfg    = cfg_wdata[KIB_CFG_W-1:0];
          default: ;
        endcase
      end
      if (byte_ch.valid && byte_ch.ready) absorb_byte(byte_ch.data_byte);
      if (entry_ch.valid && entry_ch.ready) compare_entry();
    end
    pending_count = pending_entries.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench of the index block entry parser. It streams bytes of a
// block region under a range of entry layouts and block lengths, with idle
// and stall patterns on both channels, and lets the checker beside the
// parser judge every entry that comes out.
// ----------------------------------------------------------------------------
module tb_top;
  import ibep_pkg::*;

  // The limit leaves a wide margin for the worst mix of sender gaps,
  // receiver stalls and the recalculation pass after each register
  // write.
  localparam int CYCLE_LIMIT  = 400000;
  // The parser shows an entry in the cycle after the byte that completes it,
  // so after this drain that follows the last outstanding entry nothing is in flight.
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_BYTES = 450;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_t              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending_count;
  int idle_pct;
  int stall_pct;
  int cycle_count = 0;

  ibep_byte_if  byte_ch ();
  ibep_entry_if entry_ch ();

  index_block_entry_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (byte_ch),
    .out_ch    (entry_ch)
  );

  ibep_entry_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .byte_ch       (byte_ch),
    .entry_ch      (entry_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The receiver drops ready at random in the share of cycles that the
  // current pacing mode asks for; with a share of zero it never stalls.
  always @(posedge clk) begin
    entry_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hung parser ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Pacing modes: none, sender gaps, receiver stalls, and a light mix of both.
  task automatic set_pace(input int mode);
    case (mode)
      1:       begin idle_pct = 47; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 47; end
      3:       begin idle_pct = 14; stall_pct = 14; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Offers one request on the byte channel and returns at the edge where it
  // is taken. Valid is left high so back-to-back requests need no extra
  // assignment; an idle gap lowers it first.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  // Stops sending and waits until every predicted entry has come out, then
  // DRAIN_CYCLES more for bytes that complete nothing, and finally for the
  // parser to accept again so that no register write lands on a busy block.
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Writes all four registers back to back; write enable stays high across
  // them and drops once after the last.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] key_len,
                              input logic [CFG_DATA_W-1:0] size_len,
                              input logic [CFG_DATA_W-1:0] offset_len,
                              input logic [CFG_DATA_W-1:0] kib);
    write_reg(CFG_KEY_BYTES, key_len);
    write_reg(CFG_SIZE_BYTES, size_len);
    write_reg(CFG_OFFSET_BYTES, offset_len);
    write_reg(CFG_BLOCK_KIB, kib);
    cfg_we <= 1'b0;
  endtask

  // Key lengths lean to the legal range but regularly hit zero, the top
  // value and the values above it; zero and the values above it clip.
  function automatic logic [CFG_DATA_W-1:0] pick_key_len();
    case ($urandom_range(9))
      0:       return CFG_DATA_W'(0);
      1:       return CFG_DATA_W'($urandom_range(31, 17));
      2:       return CFG_DATA_W'(KEY_BYTES_MAX);
      3:       return CFG_DATA_W'(1);
      default: return CFG_DATA_W'($urandom_range(KEY_BYTES_MAX, 1));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_field_len();
    case ($urandom_range(6))
      0:       return CFG_DATA_W'(0);
      1:       return CFG_DATA_W'(FLD_BYTES_MAX);
      2:       return CFG_DATA_W'($urandom_range(15, 9));
      default: return CFG_DATA_W'($urandom_range(8, 0));
    endcase
  endfunction

  // Short blocks are favored so that block ends and padding come up often.
  function automatic logic [CFG_DATA_W-1:0] pick_kib();
    case ($urandom_range(9))
      0:       return CFG_DATA_W'(0);
      1:       return CFG_DATA_W'(255);
      2:       return CFG_DATA_W'($urandom_range(254, 2));
      default: return CFG_DATA_W'(1);
    endcase
  endfunction

  // Share of zero bytes in a phase: from nearly none to mostly zero, where
  // all-zero keys suppress most entries.
  function automatic int pick_zero_pct();
    case ($urandom_range(3))
      0:       return 2;
      1:       return 15;
      2:       return 50;
      default: return 90;
    endcase
  endfunction

  task automatic run_phase(input int count, input int zero_pct, input int mode);
    int r;
    set_pace(mode);
    repeat (count) begin
      r = $urandom_range(99);
      if (r < zero_pct) send_byte('0);
      else if (r < zero_pct + 5) send_byte('1);
      else send_byte(BYTE_W'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] long_key [16];
    int                sent;
    int                phase;
    int                count;

    long_key = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
                 8'h01, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFE};

    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_KEY_BYTES;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    set_pace(0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Zero key length and zero block length both act as one, so every byte
    // is a whole entry: a zero byte must be dropped, the others emitted.
    settle();
    program_regs(8'd0, 8'd0, 8'd0, 8'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);

    // An over-long key length clips to sixteen bytes, filling both key words
    // with no size or offset field.
    settle();
    program_regs(8'd31, 8'd0, 8'd0, 8'd255);
    foreach (long_key[i]) send_byte(long_key[i]);

    // Oversized size and offset lengths clip to eight. The entry is left
    // half done; shrinking the entry to one byte then makes the next byte
    // finish it with the key and size collected so far.
    settle();
    program_regs(8'd2, 8'd15, 8'd9, 8'd0);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    settle();
    program_regs(8'd1, 8'd0, 8'd0, 8'd0);
    send_byte(8'h00);

    // Random phases: a fresh layout each time, written while the parser is
    // quiet but with the block and entry counters kept, so settings change
    // at arbitrary points of the stream. Pacing cycles through all modes.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BYTES) begin
      count = $urandom_range(70, 15);
      settle();
      program_regs(pick_key_len(), pick_field_len(), pick_field_len(), pick_kib());
      run_phase(count, pick_zero_pct(), phase % 4);
      sent += count;
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
